[design/lpfr_pkg.sv]
// Shared types and constants of the length-prefixed frame router.
package lpfr_pkg;

  localparam int unsigned MaxLenWidth = 24;
  localparam int unsigned IdWidth     = 32;
  localparam int unsigned CfgWidth    = 32;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
  localparam logic [1:0] KIND_EMPTY_END = 2'd1;
  localparam logic [1:0] KIND_LEN_ERROR = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAX_FRAME_LENGTH = 2'd0;
  localparam logic [1:0] REG_COMMAND_ID       = 2'd1;

  // Register reset values.
  localparam logic [MaxLenWidth-1:0] MAX_FRAME_LENGTH_RESET = 24'd262144;
  localparam logic [IdWidth-1:0]     COMMAND_ID_RESET       = 32'hFFFF_FFFF;

  // One classified result waiting between the parser and the output stage.
  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         payload;
    logic [IdWidth-1:0] dest;
    logic               last;
  } entry_t;

endpackage

[design/length_prefixed_frame_router.sv]
// Top level of the length-prefixed frame router: configuration registers and the three stages.
//
//   Channel  Direction  Handshake                   Payload
//   data     in         data_valid / data_stall     data_byte
//   result   out        result_valid / result_stall result_kind, payload_byte, dest_id,
//                                                   is_command, last_in_frame
//   cfg      in         cfg_write                   cfg_index, cfg_data
//
// One byte is accepted per cycle while data_stall is low; the parser decides it in that cycle.
// A result passes from the parser through the queue and then the output register.
// data_stall rises only when the QUEUE_DEPTH-entry queue is full, i.e. while the result side stalls.
// Reset is synchronous; it reopens a closed stream and restores both registers.
module length_prefixed_frame_router #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            data_valid,
  output logic                            data_stall,
  input  logic [7:0]                      data_byte,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic [1:0]                      result_kind,
  output logic [7:0]                      payload_byte,
  output logic [31:0]                     dest_id,
  output logic                            is_command,
  output logic                            last_in_frame,
  input  logic                            cfg_write,
  input  logic [1:0]                      cfg_index,
  input  logic [lpfr_pkg::CfgWidth-1:0]   cfg_data
);
  import lpfr_pkg::*;

  logic [MaxLenWidth-1:0] max_frame_length;
  logic [IdWidth-1:0]     command_id;

  logic   push, pop, queue_empty, queue_full;
  entry_t push_entry, head;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= MAX_FRAME_LENGTH_RESET;
      command_id       <= COMMAND_ID_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAX_FRAME_LENGTH: max_frame_length <= cfg_data[MaxLenWidth-1:0];
        REG_COMMAND_ID:       command_id       <= cfg_data[IdWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  lpfr_front u_front (
    .clk              (clk),
    .rst              (rst),
    .data_valid       (data_valid),
    .data_stall       (data_stall),
    .data_byte        (data_byte),
    .max_frame_length (max_frame_length),
    .queue_full       (queue_full),
    .push             (push),
    .push_entry       (push_entry)
  );

  lpfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty),
    .full       (queue_full)
  );

  lpfr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .queue_empty   (queue_empty),
    .head          (head),
    .pop           (pop),
    .command_id    (command_id),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .dest_id       (dest_id),
    .is_command    (is_command),
    .last_in_frame (last_in_frame)
  );

endmodule

[design/lpfr_front.sv]
// Header parser: accepts stream bytes and classifies them into result entries.
module lpfr_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               data_valid,
  output logic                               data_stall,
  input  logic [7:0]                         data_byte,
  input  logic [lpfr_pkg::MaxLenWidth-1:0]   max_frame_length,
  input  logic                               queue_full,
  output logic                               push,
  output lpfr_pkg::entry_t                   push_entry
);
  import lpfr_pkg::*;

  localparam logic [1:0] PH_LEN    = 2'd0;
  localparam logic [1:0] PH_ID     = 2'd1;
  localparam logic [1:0] PH_PAY    = 2'd2;
  localparam logic [1:0] PH_CLOSED = 2'd3;

  logic [1:0]             phase, phase_next;
  logic [1:0]             idx, idx_next;
  logic [23:0]            len_lo, len_lo_next;
  logic [IdWidth-1:0]     id_word, id_word_next;
  logic [MaxLenWidth-1:0] remaining, remaining_next;

  logic                   accept;
  logic [31:0]            len_full;
  logic [IdWidth-1:0]     id_full;
  logic [MaxLenWidth-1:0] rem_dec;

  assign data_stall = queue_full;
  assign accept     = data_valid && !queue_full;
  assign len_full   = {data_byte, len_lo};
  assign id_full    = {data_byte, id_word[23:0]};
  assign rem_dec    = remaining - MaxLenWidth'(1);

  always_comb begin
    phase_next     = phase;
    idx_next       = idx;
    len_lo_next    = len_lo;
    id_word_next   = id_word;
    remaining_next = remaining;
    push           = 1'b0;
    push_entry     = '0;
    if (accept) begin
      case (phase)
        PH_LEN: begin
          if (idx != 2'd3) begin
            len_lo_next[{idx, 3'b000} +: 8] = data_byte;
            idx_next = idx + 2'd1;
          end else begin
            idx_next = 2'd0;
            // The whole 32-bit word is checked, not just its low bytes.
            if (len_full < 32'd4 || len_full > {8'd0, max_frame_length}) begin
              phase_next      = PH_CLOSED;
              push            = 1'b1;
              push_entry.kind = KIND_LEN_ERROR;
              push_entry.last = 1'b1;
            end else begin
              remaining_next = len_full[MaxLenWidth-1:0] - MaxLenWidth'(4);
              phase_next     = PH_ID;
            end
          end
        end
        PH_ID: begin
          if (idx != 2'd3) begin
            id_word_next[{idx, 3'b000} +: 8] = data_byte;
            idx_next = idx + 2'd1;
          end else begin
            idx_next     = 2'd0;
            id_word_next = id_full;
            if (remaining == '0) begin
              phase_next      = PH_LEN;
              push            = 1'b1;
              push_entry.kind = KIND_EMPTY_END;
              push_entry.dest = id_full;
              push_entry.last = 1'b1;
            end else begin
              phase_next = PH_PAY;
            end
          end
        end
        PH_PAY: begin
          remaining_next     = rem_dec;
          push               = 1'b1;
          push_entry.kind    = KIND_PAYLOAD;
          push_entry.payload = data_byte;
          push_entry.dest    = id_word;
          push_entry.last    = (rem_dec == '0);
          if (rem_dec == '0) begin
            phase_next = PH_LEN;
          end
        end
        default: begin
          // Stream closed: bytes are swallowed until reset.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEN;
      idx       <= 2'd0;
      len_lo    <= '0;
      id_word   <= '0;
      remaining <= '0;
    end else begin
      phase     <= phase_next;
      idx       <= idx_next;
      len_lo    <= len_lo_next;
      id_word   <= id_word_next;
      remaining <= remaining_next;
    end
  end

endmodule

[design/lpfr_queue.sv]
// Short first-in first-out queue of result entries between parser and output stage.
module lpfr_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lpfr_pkg::entry_t push_entry,
  input  logic             pop,
  output lpfr_pkg::entry_t head,
  output logic             empty,
  output logic             full
);
  import lpfr_pkg::*;

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  entry_t                entries [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [CntWidth-1:0]   count;

  assign empty = (count == '0);
  assign full  = (count == CntWidth'(DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + PtrWidth'(1);
      end
      if (push && !pop) begin
        count <= count + CntWidth'(1);
      end else if (pop && !push) begin
        count <= count - CntWidth'(1);
      end
    end
  end

endmodule

[design/lpfr_back.sv]
// Output stage: takes entries from the queue, flags commands and holds the result item.
module lpfr_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           queue_empty,
  input  lpfr_pkg::entry_t               head,
  output logic                           pop,
  input  logic [lpfr_pkg::IdWidth-1:0]   command_id,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [1:0]                     result_kind,
  output logic [7:0]                     payload_byte,
  output logic [lpfr_pkg::IdWidth-1:0]   dest_id,
  output logic                           is_command,
  output logic                           last_in_frame
);
  import lpfr_pkg::*;

  assign pop = !queue_empty && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result_kind   <= head.kind;
      payload_byte  <= head.payload;
      dest_id       <= head.dest;
      // An error result never counts as a command.
      is_command    <= (head.kind != KIND_LEN_ERROR) && (head.dest == command_id);
      last_in_frame <= head.last;
    end
  end

endmodule

[tb/length_prefixed_frame_router_test.sv]
// Self-checking testbench for the length-prefixed frame router with random handshake idling.
`timescale 1ns / 1ps

module length_prefixed_frame_router_test;
  import lpfr_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_BYTES   = 150;
  localparam int NOISE_BYTES   = 24;

  // Indexes beyond the two real registers; writes to them must be ignored.
  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;

  typedef enum logic [1:0] {ST_LENGTH, ST_DEST, ST_PAYLOAD, ST_CLOSED} deframe_state_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_SOLID} stall_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] dest;
    logic        cmd;
    logic        last;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [31:0] dest_id;
  logic        is_command;
  logic        last_in_frame;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  length_prefixed_frame_router i_dut (
    .clk           (clk),
    .rst           (rst),
    .data_valid    (data_valid),
    .data_stall    (data_stall),
    .data_byte     (data_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .dest_id       (dest_id),
    .is_command    (is_command),
    .last_in_frame (last_in_frame),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Byte stream waiting to be sent, and the results the deframer is due to give.
  logic [7:0]    byte_queue[$];
  frame_result_t frame_results_q[$];

  // Mirror of the block's registers and deframing state.
  logic [23:0]    max_len_cfg = MAX_FRAME_LENGTH_RESET;
  logic [31:0]    cmd_id_cfg = COMMAND_ID_RESET;
  deframe_state_t df_state = ST_LENGTH;
  logic [1:0]     hdr_idx = 2'd0;
  logic [31:0]    len_word = 32'd0;
  logic [31:0]    id_word = 32'd0;
  logic [23:0]    remaining = 24'd0;

  int bytes_pushed = 0;
  int bytes_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;
  int frames_sent = 0;
  int empty_frames = 0;
  int command_frames = 0;
  int settings_used = 0;
  string close_desc = "nothing";

  task deframe_byte(input logic [7:0] b);
    frame_result_t r;
    r = '0;
    case (df_state)
      ST_LENGTH: begin
        len_word[{hdr_idx, 3'b000} +: 8] = b;
        if (hdr_idx != 2'd3) begin
          hdr_idx = hdr_idx + 2'd1;
        end else begin
          hdr_idx = 2'd0;
          // The whole 32-bit word is checked, so high bytes above 24 bits reject too.
          if (len_word < 32'd4 || len_word > {8'h00, max_len_cfg}) begin
            df_state = ST_CLOSED;
            r.kind = KIND_LEN_ERROR;
            r.last = 1'b1;
            frame_results_q.push_back(r);
          end else begin
            remaining = len_word[23:0] - 24'd4;
            df_state = ST_DEST;
          end
        end
      end
      ST_DEST: begin
        id_word[{hdr_idx, 3'b000} +: 8] = b;
        if (hdr_idx != 2'd3) begin
          hdr_idx = hdr_idx + 2'd1;
        end else begin
          hdr_idx = 2'd0;
          if (remaining == 24'd0) begin
            df_state = ST_LENGTH;
            r.kind = KIND_EMPTY_END;
            r.dest = id_word;
            r.cmd = (id_word == cmd_id_cfg);
            r.last = 1'b1;
            frame_results_q.push_back(r);
          end else begin
            df_state = ST_PAYLOAD;
          end
        end
      end
      ST_PAYLOAD: begin
        remaining = remaining - 24'd1;
        if (remaining == 24'd0) df_state = ST_LENGTH;
        r.kind = KIND_PAYLOAD;
        r.data = b;
        r.dest = id_word;
        r.cmd = (id_word == cmd_id_cfg);
        r.last = (remaining == 24'd0);
        frame_results_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  // Sender: bursts of random length separated by random gaps.
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
    end else begin
      if (data_valid && !data_stall) begin
        deframe_byte(data_byte);
        bytes_accepted++;
      end
      if (!data_valid || !data_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          data_valid <= 1'b0;
        end else if (byte_queue.size() > 0) begin
          data_byte <= byte_queue.pop_front();
          data_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: free-flowing, randomly stalling and solidly stalling stretches.
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            stall_mode = STALL_NONE;
            stall_hold = $urandom_range(10, 60);
          end
          4, 5, 6: begin
            stall_mode = STALL_RANDOM;
            stall_hold = $urandom_range(20, 80);
          end
          default: begin
            stall_mode = STALL_SOLID;
            stall_hold = $urandom_range(1, 12);
          end
        endcase
      end else begin
        stall_hold--;
      end
      case (stall_mode)
        STALL_NONE:   result_stall <= 1'b0;
        STALL_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
        default:      result_stall <= 1'b1;
      endcase
    end
  end

  frame_result_t seen;
  frame_result_t want;

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      seen.kind = result_kind;
      seen.data = payload_byte;
      seen.dest = dest_id;
      seen.cmd  = is_command;
      seen.last = last_in_frame;
      if (frame_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ERROR: unexpected result kind %0d byte %02h id %08h cmd %0b last %0b",
                   seen.kind, seen.data, seen.dest, seen.cmd, seen.last);
      end else begin
        want = frame_results_q.pop_front();
        results_checked++;
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result %0d expected kind %0d byte %02h id %08h cmd %0b last %0b",
                     results_checked, want.kind, want.data, want.dest, want.cmd, want.last);
            $display("       got kind %0d byte %02h id %08h cmd %0b last %0b",
                     seen.kind, seen.data, seen.dest, seen.cmd, seen.last);
          end
        end
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out with %0d results outstanding", frame_results_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task push_byte(input logic [7:0] b);
    byte_queue.push_back(b);
    bytes_pushed++;
  endtask

  task push_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) push_byte(w[8*i +: 8]);
  endtask

  task queue_header(input logic [31:0] length, input logic [31:0] dest);
    push_word(length);
    push_word(dest);
    frames_sent++;
    if (length == 32'd4) empty_frames++;
    if (dest == cmd_id_cfg) command_frames++;
  endtask

  task write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == REG_MAX_FRAME_LENGTH) max_len_cfg = value[MaxLenWidth-1:0];
    else if (idx == REG_COMMAND_ID) cmd_id_cfg = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Junk in the upper byte checks that the length register keeps only 24 bits.
  task set_config(input logic [23:0] max_len, input logic [31:0] cmd);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_MAX_FRAME_LENGTH, {junk[7:0], max_len});
    write_reg(REG_COMMAND_ID, cmd);
    settings_used++;
  endtask

  // Registers are only touched once the stream and the result pipeline are empty.
  task wait_idle;
    @(posedge clk);
    while (bytes_accepted != bytes_pushed || frame_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task queue_random_frames(input int budget);
    int          start;
    int          lim;
    int          n;
    logic [31:0] dest;
    logic [31:0] flip;
    start = bytes_pushed;
    lim = int'(max_len_cfg) - 4;
    if (lim > 200) lim = 200;
    while (bytes_pushed - start < budget) begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        1:       n = lim;
        default: n = (lim == 0) ? 0 : $urandom_range(1, (lim < 24) ? lim : 24);
      endcase
      flip = 32'd1 << $urandom_range(0, 31);
      case ($urandom_range(0, 5))
        0, 1:    dest = cmd_id_cfg;
        2:       dest = cmd_id_cfg ^ flip;
        3:       dest = 32'h0000_0000;
        4:       dest = 32'hFFFF_FFFF;
        default: dest = $urandom;
      endcase
      queue_header(32'd4 + n, dest);
      for (int i = 0; i < n; i++) push_byte(8'($urandom));
    end
  endtask

  int          close_mode;
  logic [31:0] rnd;

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset settings: an empty command frame, payload extremes.
    queue_header(32'd4, COMMAND_ID_RESET);
    queue_header(32'd6, 32'h0000_0000);
    push_byte(8'h00);
    push_byte(8'hFF);
    queue_header(32'd5, 32'h8000_0001);
    push_byte(8'($urandom));

    for (int k = 0; k < 6; k++) begin
      wait_idle();
      case (k)
        0: set_config(24'd4, $urandom);
        1: set_config(24'hFF_FFFF, 32'h0000_0000);
        2: begin
          set_config(24'($urandom_range(5, 40)), $urandom);
          write_reg(REG_SPARE_2, $urandom);
        end
        3: set_config(MAX_FRAME_LENGTH_RESET, COMMAND_ID_RESET);
        default: begin
          set_config(24'($urandom_range(4, 300)), $urandom);
          write_reg(REG_SPARE_3, $urandom);
        end
      endcase
      queue_random_frames(PHASE_BYTES);
    end

    // Only one length error is possible per run, since it closes the stream until reset.
    wait_idle();
    close_mode = $urandom_range(0, 3);
    case (close_mode)
      0: begin
        set_config(24'($urandom_range(4, 64)), $urandom);
        queue_random_frames(30);
        push_word($urandom_range(0, 3));
        close_desc = "a length below four";
      end
      1: begin
        set_config(24'($urandom_range(4, 64)), $urandom);
        queue_random_frames(30);
        push_word({8'h00, max_len_cfg} + 32'd1);
        close_desc = "a length one above the maximum";
      end
      2: begin
        set_config(24'hFF_FFFF, $urandom);
        queue_random_frames(30);
        rnd = $urandom;
        rnd[31:24] = 8'($urandom_range(1, 255));
        push_word(rnd);
        close_desc = "a length beyond 24 bits";
      end
      default: begin
        set_config(24'($urandom_range(0, 3)), $urandom);
        push_word($urandom_range(4, 40));
        close_desc = "a maximum below four";
      end
    endcase
    // Everything after the error must be swallowed silently.
    for (int i = 0; i < NOISE_BYTES; i++) push_byte(8'($urandom));
    wait_idle();
    repeat (20) @(posedge clk);

    $display("Covered %0d frames (%0d empty, %0d to the command id) under %0d register settings.",
             frames_sent, empty_frames, command_frames, settings_used);
    $display("%0d bytes accepted, %0d results checked; the stream was closed by %s.",
             bytes_accepted, results_checked, close_desc);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
